[rtl/core/nmsd_pkg.sv]
package nmsd_pkg;

  localparam int PERIOD_DEF     = 22;
  localparam int SHIFT_BITS_DEF = 24;

  localparam int DIGIT_W     = 4;
  localparam int DIGIT_CODES = 10;   // decoder outputs 0 to 9
  localparam int CODE_W      = 32;   // widest shifted word
  localparam int IN_TDATA_W  = 24;
  localparam int OUT_TDATA_W = 8;

  localparam logic [DIGIT_W-1:0] DIGIT_DARK = DIGIT_W'(10);

  // blank select codes
  localparam logic [1:0] BLANK_FIRST  = 2'b01;
  localparam logic [1:0] BLANK_SECOND = 2'b10;

  // anode level codes
  localparam logic [1:0] ANODE_OFF  = 2'b00;
  localparam logic [1:0] ANODE_ZERO = 2'b01;
  localparam logic [1:0] ANODE_ONE  = 2'b10;

  typedef struct packed {
    logic [DIGIT_W-1:0] first_digit_a;
    logic [DIGIT_W-1:0] second_digit_a;
    logic [DIGIT_W-1:0] first_digit_b;
    logic [DIGIT_W-1:0] second_digit_b;
    logic               display_enable;
    logic               blink_active;
    logic [1:0]         blank_select;
  } tick_t;

  // control handed from the phase logic to the serialiser with each job
  typedef struct packed {
    logic       is_write;
    logic [1:0] anode_before;
    logic [1:0] anode_after;
  } job_ctrl_t;

  function automatic logic [DIGIT_CODES-1:0] one_hot(input logic [DIGIT_W-1:0] v);
    logic [DIGIT_CODES-1:0] r;
    r = '0;
    if (v < DIGIT_W'(DIGIT_CODES)) begin
      r[v] = 1'b1;
    end
    return r;
  endfunction

endpackage

[rtl/core/nmsd_phase.sv]
module nmsd_phase #(
  parameter int PERIOD     = nmsd_pkg::PERIOD_DEF,
  parameter int SHIFT_BITS = nmsd_pkg::SHIFT_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  load,
  input  nmsd_pkg::tick_t       tick,
  output nmsd_pkg::job_ctrl_t   job,
  output logic [SHIFT_BITS-1:0] word
);

  localparam int PH_W = $clog2(PERIOD);
  localparam int HALF = PERIOD / 2;

  logic [PH_W-1:0] phase_count;
  logic [1:0]      anode_levels;
  logic [PH_W-1:0] ph;
  logic            sel_a;
  logic            sel_b;
  logic [nmsd_pkg::DIGIT_W-1:0] v1;
  logic [nmsd_pkg::DIGIT_W-1:0] v2;
  logic [nmsd_pkg::CODE_W-1:0]  code;

  always_comb begin
    // out of range counts are taken as phase zero
    ph = ({1'b0, phase_count} >= (PH_W+1)'(PERIOD)) ? '0 : phase_count;
    sel_a = tick.display_enable && (ph >= PH_W'(1)) && (ph < PH_W'(HALF));
    sel_b = tick.display_enable && (ph > PH_W'(HALF));

    v1 = sel_a ? tick.first_digit_a  : tick.first_digit_b;
    v2 = sel_a ? tick.second_digit_a : tick.second_digit_b;
    if (tick.blink_active) begin
      if ((tick.blank_select & nmsd_pkg::BLANK_FIRST) != 2'b00) begin
        v1 = nmsd_pkg::DIGIT_DARK;
      end
      if ((tick.blank_select & nmsd_pkg::BLANK_SECOND) != 2'b00) begin
        v2 = nmsd_pkg::DIGIT_DARK;
      end
    end
    code = (nmsd_pkg::CODE_W'(nmsd_pkg::one_hot(v2)) << nmsd_pkg::DIGIT_CODES)
         | nmsd_pkg::CODE_W'(nmsd_pkg::one_hot(v1));
    word = ~code[SHIFT_BITS-1:0];

    job.is_write     = sel_a || sel_b;
    job.anode_before = anode_levels;
    if (sel_a) begin
      job.anode_after = anode_levels | nmsd_pkg::ANODE_ZERO;
    end else if (sel_b) begin
      job.anode_after = anode_levels | nmsd_pkg::ANODE_ONE;
    end else begin
      job.anode_after = nmsd_pkg::ANODE_OFF;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase_count  <= '0;
      anode_levels <= nmsd_pkg::ANODE_OFF;
    end else if (load) begin
      phase_count  <= (ph == PH_W'(PERIOD - 1)) ? '0 : ph + PH_W'(1);
      anode_levels <= job.anode_after;
    end
  end

endmodule

[rtl/core/nmsd_serialiser.sv]
module nmsd_serialiser #(
  parameter int SHIFT_BITS = nmsd_pkg::SHIFT_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  load,
  input  nmsd_pkg::job_ctrl_t   job,
  input  logic [SHIFT_BITS-1:0] word_in,
  output logic                  free,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic                  serial_bit,
  output logic                  shift_pulse,
  output logic                  latch_pulse,
  output logic                  anode_zero,
  output logic                  anode_one,
  output logic                  last
);

  localparam int CNT_W = $clog2(SHIFT_BITS + 1);

  logic                  busy;
  logic [CNT_W-1:0]      cnt;
  logic [SHIFT_BITS-1:0] word;
  nmsd_pkg::job_ctrl_t   ctrl;
  logic                  latch_step;
  logic                  shift_step;
  logic                  out_fire;
  logic                  done;

  always_comb begin
    latch_step  = ctrl.is_write && (cnt == CNT_W'(SHIFT_BITS));
    shift_step  = ctrl.is_write && !latch_step;
    out_fire    = busy && out_ready;
    done        = out_fire && (!ctrl.is_write || latch_step);
    free        = !busy || done;
    out_valid   = busy;
    serial_bit  = shift_step && word[SHIFT_BITS-1];
    shift_pulse = shift_step;
    latch_pulse = latch_step;
    // shift words still show the levels from before the tick
    anode_zero  = shift_step ? ctrl.anode_before[0] : ctrl.anode_after[0];
    anode_one   = shift_step ? ctrl.anode_before[1] : ctrl.anode_after[1];
    last        = !ctrl.is_write || latch_step;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (load) begin
      busy <= 1'b1;
      cnt  <= '0;
    end else if (done) begin
      busy <= 1'b0;
    end else if (out_fire) begin
      cnt  <= cnt + CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      word <= word_in;
      ctrl <= job;
    end else if (out_fire) begin
      word <= word << 1;
    end
  end

endmodule

[rtl/core/nixie_multiplex_shift_driver_top.sv]
// channel   | dir | tdata (lowest bit up)                                     | tlast
// ----------+-----+-----------------------------------------------------------+---------------
// s_axis    | in  | first_digit_a[3:0] second_digit_a[3:0] first_digit_b[3:0] | -
//           |     | second_digit_b[3:0] display_enable blink_active           |
//           |     | blank_select[1:0], zero pad to 24                         |
// m_axis    | out | serial_bit shift_pulse latch_pulse anode_zero anode_one,  | last
//           |     | zero pad to 8                                             |
//
// a write tick gives SHIFT_BITS + 1 output words (one per shift bit, then the latch),
// an anode clear tick gives one; the serialiser's bit counter steps through the words,
// and the serialiser takes no new tick until the last word of the current one goes out
// a one-word input register takes the next tick while the serialiser is still busy
// synchronous reset clears the phase counter, anode levels and both valid flags
// an output stall freezes the serialiser; a full input register stalls while it cannot load
module nixie_multiplex_shift_driver_top #(
  parameter int PERIOD     = nmsd_pkg::PERIOD_DEF,
  parameter int SHIFT_BITS = nmsd_pkg::SHIFT_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  // first_digit_a, second_digit_a, first_digit_b, second_digit_b,
  // display_enable, blink_active, blank_select
  input  logic [nmsd_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // serial_bit, shift_pulse, latch_pulse, anode_zero, anode_one
  output logic [nmsd_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
  output logic                             m_axis_tlast
);

  logic                  in_valid;
  nmsd_pkg::tick_t       in_tick;
  logic                  ser_free;
  logic                  load;
  nmsd_pkg::job_ctrl_t   job;
  logic [SHIFT_BITS-1:0] job_word;
  logic                  serial_bit;
  logic                  shift_pulse;
  logic                  latch_pulse;
  logic                  anode_zero;
  logic                  anode_one;

  // tick moves into the serialiser as soon as the previous one has gone out
  assign load          = in_valid && ser_free;
  assign s_axis_tready = !in_valid || load;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid <= s_axis_tvalid;
    end
  end

  // input word register, unpacked from the bus layout
  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_tick.first_digit_a  <= s_axis_tdata[3:0];
      in_tick.second_digit_a <= s_axis_tdata[7:4];
      in_tick.first_digit_b  <= s_axis_tdata[11:8];
      in_tick.second_digit_b <= s_axis_tdata[15:12];
      in_tick.display_enable <= s_axis_tdata[16];
      in_tick.blink_active   <= s_axis_tdata[17];
      in_tick.blank_select   <= s_axis_tdata[19:18];
    end
  end

  // phase counter, anode state and digit encoding
  nmsd_phase #(
    .PERIOD     (PERIOD),
    .SHIFT_BITS (SHIFT_BITS)
  ) u_phase (
    .clk  (clk),
    .rst  (rst),
    .load (load),
    .tick (in_tick),
    .job  (job),
    .word (job_word)
  );

  // bit-by-bit output of the encoded word followed by the latch strobe, or one anode word
  nmsd_serialiser #(
    .SHIFT_BITS (SHIFT_BITS)
  ) u_ser (
    .clk         (clk),
    .rst         (rst),
    .load        (load),
    .job         (job),
    .word_in     (job_word),
    .free        (ser_free),
    .out_valid   (m_axis_tvalid),
    .out_ready   (m_axis_tready),
    .serial_bit  (serial_bit),
    .shift_pulse (shift_pulse),
    .latch_pulse (latch_pulse),
    .anode_zero  (anode_zero),
    .anode_one   (anode_one),
    .last        (m_axis_tlast)
  );

  assign m_axis_tdata = {3'b000, anode_one, anode_zero, latch_pulse, shift_pulse, serial_bit};

endmodule

[rtl/core/nmsd_checker.sv]
module nmsd_checker (
  input logic                             clk,
  input logic                             rst,
  input logic                             m_axis_tvalid,
  input logic                             m_axis_tready,
  input logic [nmsd_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
  input logic                             m_axis_tlast
);

  // a stalled word stays offered
  a_hold_valid: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("output word dropped while stalled");

  // the latch strobe always closes a tick
  a_latch_last: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tdata[2] |-> m_axis_tlast)
    else $error("latch word without tlast");

  // a shift word is never the end of a tick
  a_shift_not_last: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tdata[1] |-> !m_axis_tlast && !m_axis_tdata[2])
    else $error("shift word marked last or latching");

  // anodes pass through an off phase between switching, so never both on
  a_anode_excl: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> !(m_axis_tdata[3] && m_axis_tdata[4]))
    else $error("both anodes on");

endmodule

bind nixie_multiplex_shift_driver_top nmsd_checker u_nmsd_checker (
  .clk           (clk),
  .rst           (rst),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tlast  (m_axis_tlast)
);
